[rtl/cdn_pkg.sv]
`default_nettype none

package cdn_pkg;

    // One input item as it arrives on the push side.
    typedef struct packed {
        logic signed [15:0] sec_in;
        logic signed [15:0] min_in;
        logic signed [15:0] hour_in;
        logic [9:0]         day_in;
        logic [3:0]         month_in;
        logic [11:0]        year_in;
    } t_in_item;

    // One result item as it leaves on the pop side.
    typedef struct packed {
        logic [5:0]  sec_out;
        logic [5:0]  min_out;
        logic [4:0]  hour_out;
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [11:0] year_out;
        logic [1:0]  status;
    } t_out_item;

    // Work handed from the front end to the month walker.
    typedef struct packed {
        logic [5:0]         sec;
        logic [5:0]         min;
        logic [4:0]         hour;
        logic signed [12:0] day;
        logic [3:0]         month;
        logic [11:0]        year;
        logic [8:0]         year_mod400;
    } t_job;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DAY_UNDER = 2'd1;
    localparam logic [1:0] ST_YEAR_OVER = 2'd2;

    localparam logic [11:0] YEAR_MAX = 12'd4095;

    // Division steps of the front end, in the order they run.
    localparam logic [1:0] OP_SEC  = 2'd0;
    localparam logic [1:0] OP_MIN  = 2'd1;
    localparam logic [1:0] OP_HOUR = 2'd2;
    localparam logic [1:0] OP_YEAR = 2'd3;

    // Quotients come from a reciprocal product shifted right by this much.
    localparam int RECIP_SHIFT = 22;

    // Biases that make each dividend non-negative before division.
    localparam logic [16:0] SEC_BIAS  = 17'd32820;
    localparam logic [17:0] MIN_BIAS  = 18'd33360;
    localparam logic [17:0] HOUR_BIAS = 18'd33336;

    // Divisor of each step.
    function automatic logic [8:0] divisor(input logic [1:0] op);
        logic [8:0] d;
        case (op)
            OP_SEC:  d = 9'd60;
            OP_MIN:  d = 9'd60;
            OP_HOUR: d = 9'd24;
            default: d = 9'd400;
        endcase
        return d;
    endfunction

    // floor(2^RECIP_SHIFT / divisor) for each step.
    function automatic logic [17:0] recip(input logic [1:0] op);
        logic [17:0] m;
        case (op)
            OP_SEC:  m = 18'd69905;
            OP_MIN:  m = 18'd69905;
            OP_HOUR: m = 18'd174762;
            default: m = 18'd10485;
        endcase
        return m;
    endfunction

    // Quotient offset that undoes the bias added to the dividend.
    function automatic logic [10:0] quot_bias(input logic [1:0] op);
        logic [10:0] b;
        case (op)
            OP_SEC:  b = 11'd547;
            OP_MIN:  b = 11'd556;
            OP_HOUR: b = 11'd1389;
            default: b = 11'd0;
        endcase
        return b;
    endfunction

    // Length of a month, with February stretched in leap years.
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] n;
        case (month)
            4'd1:    n = 5'd31;
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd3:    n = 5'd31;
            4'd4:    n = 5'd30;
            4'd5:    n = 5'd31;
            4'd6:    n = 5'd30;
            4'd7:    n = 5'd31;
            4'd8:    n = 5'd31;
            4'd9:    n = 5'd30;
            4'd10:   n = 5'd31;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

[rtl/cdn_front.sv]
`default_nettype none

module cdn_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    output logic               o_full,
    input  cdn_pkg::t_in_item  i_data,
    output logic               o_job_valid,
    output cdn_pkg::t_job      o_job,
    input  wire                i_job_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_QUO  = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_op, n_op;
    cdn_pkg::t_in_item r_item;
    logic [16:0]       r_u;
    logic [34:0]       r_prod;
    logic [12:0]       r_q;
    logic [16:0]       r_rem;
    cdn_pkg::t_job     r_job;

    logic [8:0]  w_div;
    logic [12:0] w_q0;
    logic        w_over;
    logic [16:0] w_rem;
    logic [12:0] w_q;
    logic [14:0] w_qs;
    logic [17:0] w_qs_ext;
    logic [17:0] w_min_sum;
    logic [17:0] w_hour_sum;
    logic [12:0] w_day_sum;

    // Quotient correction: the reciprocal estimate is low by at most one.
    assign w_div    = cdn_pkg::divisor(r_op);
    assign w_q0     = r_prod[34:cdn_pkg::RECIP_SHIFT];
    assign w_over   = (r_rem >= {8'd0, w_div});
    assign w_rem    = w_over ? (r_rem - {8'd0, w_div}) : r_rem;
    assign w_q      = r_q + {12'd0, w_over};
    assign w_qs     = {2'b00, w_q} - {4'd0, cdn_pkg::quot_bias(r_op)};
    assign w_qs_ext = {{3{w_qs[14]}}, w_qs};

    // Carries into the next field, biased again for the next division.
    assign w_min_sum  = {{2{r_item.min_in[15]}}, r_item.min_in} + w_qs_ext
                        + cdn_pkg::MIN_BIAS;
    assign w_hour_sum = {{2{r_item.hour_in[15]}}, r_item.hour_in} + w_qs_ext
                        + cdn_pkg::HOUR_BIAS;
    assign w_day_sum  = {3'd0, r_item.day_in} + w_qs[12:0];

    // Sequencer state.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_push) begin
                    n_state = S_MUL;
                    n_op    = cdn_pkg::OP_SEC;
                end
            end
            S_MUL:  n_state = S_QUO;
            S_QUO:  n_state = S_FIX;
            S_FIX: begin
                if (r_op == cdn_pkg::OP_YEAR) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_MUL;
                    n_op    = r_op + 2'd1;
                end
            end
            S_PUSH: begin
                if (i_job_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= cdn_pkg::OP_SEC;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // Datapath: one reciprocal multiply, one remainder, one correction per field.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_data;
                r_u    <= {i_data.sec_in[15], i_data.sec_in} + cdn_pkg::SEC_BIAS;
            end
            S_MUL: begin
                r_prod <= {18'd0, r_u} * {17'd0, cdn_pkg::recip(r_op)};
            end
            S_QUO: begin
                r_q   <= w_q0;
                r_rem <= r_u - 17'({4'd0, w_q0} * {8'd0, w_div});
            end
            S_FIX: begin
                case (r_op)
                    cdn_pkg::OP_SEC: begin
                        r_job.sec <= w_rem[5:0];
                        r_u       <= w_min_sum[16:0];
                    end
                    cdn_pkg::OP_MIN: begin
                        r_job.min <= w_rem[5:0];
                        r_u       <= w_hour_sum[16:0];
                    end
                    cdn_pkg::OP_HOUR: begin
                        r_job.hour <= w_rem[4:0];
                        r_job.day  <= w_day_sum;
                        r_u        <= {5'd0, r_item.year_in};
                    end
                    default: begin
                        r_job.year_mod400 <= w_rem[8:0];
                        r_job.year        <= r_item.year_in;
                        // Month 0 counts as January, months past 12 as December.
                        if (r_item.month_in == 4'd0) begin
                            r_job.month <= 4'd1;
                        end else if (r_item.month_in > 4'd12) begin
                            r_job.month <= 4'd12;
                        end else begin
                            r_job.month <= r_item.month_in;
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_full      = (r_state != S_IDLE);
    assign o_job_valid = (r_state == S_PUSH);
    assign o_job       = r_job;

endmodule

`default_nettype wire

[rtl/cdn_queue.sv]
`default_nettype none

module cdn_queue #(
    parameter int DEPTH = 2
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    output logic               o_full,
    input  cdn_pkg::t_job      i_data,
    output logic               o_valid,
    input  wire                i_pop,
    output cdn_pkg::t_job      o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    cdn_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_wr, w_rd;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/cdn_back.sv]
`default_nettype none

module cdn_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_job_valid,
    input  cdn_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  wire                i_pop,
    output cdn_pkg::t_out_item o_data
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RUN  = 2'd1;
    localparam logic [1:0] B_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [11:0]        r_day;
    logic [3:0]         r_month;
    logic [11:0]        r_year;
    logic [8:0]         r_y400;
    logic [1:0]         r_status;
    logic [5:0]         r_sec, r_min;
    logic [4:0]         r_hour;
    cdn_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic        w_leap;
    logic [4:0]  w_len;
    logic        w_step;
    logic        w_load_out;
    logic        w_underflow;

    // Gregorian leap rule, read off the year modulo 400.
    assign w_leap = (r_y400[1:0] == 2'd0) && (r_y400 != 9'd100)
                    && (r_y400 != 9'd200) && (r_y400 != 9'd300);
    assign w_len  = cdn_pkg::month_days(r_month, w_leap);
    assign w_step = (r_day > {7'd0, w_len});

    assign w_underflow = i_job.day[12] || (i_job.day == 13'd0);
    assign o_job_pop   = (r_state == B_IDLE) && i_job_valid;
    assign w_load_out  = (r_state == B_DONE) && (!r_out_valid || i_pop);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid) begin
                    n_state = w_underflow ? B_DONE : B_RUN;
                end
            end
            B_RUN: begin
                if (!w_step) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (w_load_out) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Month walk: take off one whole month of days per cycle.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_sec   <= i_job.sec;
                r_min   <= i_job.min;
                r_hour  <= i_job.hour;
                r_month <= i_job.month;
                r_year  <= i_job.year;
                r_y400  <= i_job.year_mod400;
                if (w_underflow) begin
                    r_day    <= 12'd0;
                    r_status <= cdn_pkg::ST_DAY_UNDER;
                end else begin
                    r_day    <= i_job.day[11:0];
                    r_status <= cdn_pkg::ST_OK;
                end
            end
            B_RUN: begin
                if (w_step) begin
                    r_day <= r_day - {7'd0, w_len};
                    if (r_month == 4'd12) begin
                        r_month <= 4'd1;
                        if (r_year == cdn_pkg::YEAR_MAX) begin
                            r_status <= cdn_pkg::ST_YEAR_OVER;
                        end else begin
                            r_year <= r_year + 12'd1;
                            r_y400 <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                        end
                    end else begin
                        r_month <= r_month + 4'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Output register holds a finished result until it is taken.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.sec_out   <= r_sec;
            r_out.min_out   <= r_min;
            r_out.hour_out  <= r_hour;
            r_out.day_out   <= r_day[4:0];
            r_out.month_out <= r_month;
            r_out.year_out  <= r_year;
            r_out.status    <= r_status;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[rtl/calendar_datetime_normalizer.sv]
`default_nettype none

// Gregorian date-time normalizer.
// Input side is a queue write port: present an item on i_data with i_push;
// it is taken at a rising edge where i_push is high and o_full is low.
// Result side is a queue read port: while o_empty is low the oldest result
// sits on o_data, and it is taken at an edge where i_pop is high.
// Seconds, minutes and hours are carried by floor division (60, 60, 24),
// then whole months are subtracted from the day, one month per cycle.
// The front end takes one item at a time and runs four divisions (three
// fields and the year modulo 400), each a reciprocal multiply, a remainder
// and a one-step correction. The back end walks one month per step, skips
// the walk on a day underflow, and carries up to about 80 months for the
// largest hour carries; the slower of the two ends sets the sustained rate.
// A job queue between the two ends lets the front end accept and divide
// the next item while the back end works or while a finished result waits
// in the output register for a pop.
// Synchronous reset empties the queue and the output register and returns
// both ends to idle.
module calendar_datetime_normalizer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    output logic               o_full,
    input  cdn_pkg::t_in_item  i_data,
    output logic               o_empty,
    input  wire                i_pop,
    output cdn_pkg::t_out_item o_data
);

    logic          w_f_valid, w_f_ready;
    cdn_pkg::t_job w_f_job;
    logic          w_q_full, w_q_valid, w_q_pop;
    cdn_pkg::t_job w_q_job;

    assign w_f_ready = !w_q_full;

    cdn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_data      (i_data),
        .o_job_valid (w_f_valid),
        .o_job       (w_f_job),
        .i_job_ready (w_f_ready)
    );

    cdn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .o_full  (w_q_full),
        .i_data  (w_f_job),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_job)
    );

    cdn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_q_valid),
        .i_job       (w_q_job),
        .o_job_pop   (w_q_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire

[rtl/cdn_checker.sv]
`default_nettype none

module cdn_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_push,
    input wire                o_full,
    input wire                o_empty,
    input wire                i_pop,
    input cdn_pkg::t_out_item o_data
);

    // Reset leaves no result on the read side.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result shown right after reset");

    // A waiting result stays put until it is popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_data)))
        else $error("waiting result changed or vanished");

    // The front end is busy right after a transfer in.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full) |=> o_full)
        else $error("second item accepted before the first was divided");

    // Day underflow, and only day underflow, reports day zero.
    a_day_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((o_data.status == cdn_pkg::ST_DAY_UNDER) ==
                      (o_data.day_out == 5'd0)))
        else $error("day zero and underflow status disagree");

    // Time fields and the month come out in range.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_data.sec_out < 6'd60 && o_data.min_out < 6'd60
                      && o_data.hour_out < 5'd24 && o_data.month_out != 4'd0
                      && o_data.month_out < 4'd13))
        else $error("normalized field out of range");

endmodule

bind calendar_datetime_normalizer cdn_checker u_cdn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_push  (i_push),
    .o_full  (o_full),
    .o_empty (o_empty),
    .i_pop   (i_pop),
    .o_data  (o_data)
);

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

    // Clock, reset and the block's ports.
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               pop = 1'b0;
    logic               full;
    logic               empty;
    cdn_pkg::t_in_item  in_data = '0;
    cdn_pkg::t_out_item out_data;

    // Items waiting to be driven, and normalized date-times still to come out.
    cdn_pkg::t_in_item  pending_items[$];
    cdn_pkg::t_out_item expected_results[$];

    int mismatch_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    calendar_datetime_normalizer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_data  (in_data),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (out_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor division with a remainder in 0..d-1, borrowing for negative values.
    function automatic int floor_div(input int v, input int d, output int rem);
        int q;
        int r;
        q = v / d;
        r = v % d;
        if (r < 0) begin
            r = r + d;
            q = q - 1;
        end
        rem = r;
        return q;
    endfunction

    function automatic bit is_leap(input int y);
        if (y % 4 != 0)
            return 1'b0;
        return (y % 100 != 0) || (y % 400 == 0);
    endfunction

    function automatic int month_length(input int y, input int m);
        int n;
        case (m)
            2:              n = is_leap(y) ? 29 : 28;
            4, 6, 9, 11:    n = 30;
            default:        n = 31;
        endcase
        return n;
    endfunction

    // Expected normalized date-time for one input item.
    function automatic cdn_pkg::t_out_item normalize_datetime(input cdn_pkg::t_in_item it);
        int s;
        int mi;
        int h;
        int d;
        int rs;
        int rm;
        int rh;
        int mo;
        int y;
        int day;
        logic [1:0] st;
        cdn_pkg::t_out_item r;
        s  = int'(it.sec_in);
        mi = int'(it.min_in);
        h  = int'(it.hour_in);
        d  = int'(it.day_in);
        mo = int'(it.month_in);
        y  = int'(it.year_in);
        st = cdn_pkg::ST_OK;
        // Out-of-range months are clamped into 1..12.
        if (mo == 0)
            mo = 1;
        if (mo > 12)
            mo = 12;
        mi = mi + floor_div(s, 60, rs);
        h  = h + floor_div(mi, 60, rm);
        d  = d + floor_div(h, 24, rh);
        // A day below 1 is only flagged; otherwise whole months are removed.
        if (d < 1) begin
            day = 0;
            st  = cdn_pkg::ST_DAY_UNDER;
        end else begin
            day = d;
            while (day > month_length(y, mo)) begin
                day = day - month_length(y, mo);
                mo  = mo + 1;
                if (mo > 12) begin
                    mo = 1;
                    if (y >= int'(cdn_pkg::YEAR_MAX))
                        st = cdn_pkg::ST_YEAR_OVER;
                    else
                        y = y + 1;
                end
            end
        end
        r.sec_out   = rs[5:0];
        r.min_out   = rm[5:0];
        r.hour_out  = rh[4:0];
        r.day_out   = day[4:0];
        r.month_out = mo[3:0];
        r.year_out  = y[11:0];
        r.status    = st;
        return r;
    endfunction

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic add_item(input int s, input int mi, input int h, input int d,
                            input int mo, input int y);
        cdn_pkg::t_in_item it;
        it.sec_in   = 16'(s);
        it.min_in   = 16'(mi);
        it.hour_in  = 16'(h);
        it.day_in   = 10'(d);
        it.month_in = 4'(mo);
        it.year_in  = 12'(y);
        pending_items.push_back(it);
    endtask

    // Compares one popped result with the oldest expected one.
    task automatic check_result(input cdn_pkg::t_out_item got);
        cdn_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            $error("result with no item outstanding: %h", got);
            mismatch_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.sec_out !== want.sec_out) begin
                $error("sec_out: expected %0d, got %0d", want.sec_out, got.sec_out);
                mismatch_count++;
            end
            if (got.min_out !== want.min_out) begin
                $error("min_out: expected %0d, got %0d", want.min_out, got.min_out);
                mismatch_count++;
            end
            if (got.hour_out !== want.hour_out) begin
                $error("hour_out: expected %0d, got %0d", want.hour_out, got.hour_out);
                mismatch_count++;
            end
            if (got.day_out !== want.day_out) begin
                $error("day_out: expected %0d, got %0d", want.day_out, got.day_out);
                mismatch_count++;
            end
            if (got.month_out !== want.month_out) begin
                $error("month_out: expected %0d, got %0d", want.month_out, got.month_out);
                mismatch_count++;
            end
            if (got.year_out !== want.year_out) begin
                $error("year_out: expected %0d, got %0d", want.year_out, got.year_out);
                mismatch_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatch_count++;
            end
        end
    endtask

    // Driver: presents pending items, holds each until its transfer, then may idle for a random gap.
    always @(posedge clk) begin : driver
        logic took;
        took = push && !full;
        if (!rst_n) begin
            push     <= 1'b0;
            send_gap <= 0;
        end else begin
            if (took)
                expected_results.push_back(normalize_datetime(in_data));
            if (push && !took) begin
                // Stalled: keep the item on the port.
            end else if (send_gap != 0) begin
                push     <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_items.size() != 0) begin
                if ($urandom_range(0, 63) == 0)
                    send_burst = !send_burst;
                in_data  <= pending_items.pop_front();
                push     <= 1'b1;
                send_gap <= draw_gap(send_burst);
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: pops results with random stalls and checks each transfer.
    always @(posedge clk) begin : monitor
        logic got;
        got = pop && !empty;
        if (!rst_n) begin
            pop      <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (got)
                check_result(out_data);
            if (got || !pop) begin
                if (recv_gap != 0) begin
                    pop      <= 1'b0;
                    recv_gap <= recv_gap - 1;
                end else begin
                    if ($urandom_range(0, 63) == 0)
                        recv_burst = !recv_burst;
                    pop      <= 1'b1;
                    recv_gap <= draw_gap(recv_burst);
                end
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin : stimulus
        int kind;
        int y;
        // Directed: field extremes, leap rules, clamped months, underflow, overflow.
        add_item(0, 0, 0, 1, 1, 2000);
        add_item(59, 59, 23, 31, 12, 4095);
        add_item(32767, 32767, 32767, 1023, 12, 4095);
        add_item(-32768, -32768, -32768, 1023, 1, 0);
        add_item(-1, 0, 0, 1, 1, 2024);
        add_item(0, 0, 0, 0, 5, 100);
        add_item(0, 0, 0, 29, 2, 2000);
        add_item(0, 0, 0, 29, 2, 1900);
        add_item(0, 0, 0, 29, 2, 2004);
        add_item(0, 0, 0, 30, 2, 2004);
        add_item(0, 0, 24, 31, 12, 1999);
        add_item(0, 0, 0, 15, 0, 2001);
        add_item(0, 0, 0, 15, 13, 2001);
        add_item(0, 0, 0, 40, 15, 2001);
        add_item(60, 60, 0, 1, 1, 1);
        add_item(-60, -60, -24, 2, 3, 2000);
        add_item(0, 0, 0, 1023, 2, 0);
        add_item(0, 0, 32767, 1023, 1, 4094);
        add_item(-32768, 32767, 0, 300, 6, 2100);
        add_item(32767, -32768, 12, 500, 11, 3999);
        add_item(0, 0, 0, 366, 1, 4095);
        add_item(0, 0, -1, 1, 3, 2023);

        // Random: mostly plausible date-times near leap and year boundaries.
        repeat (1400) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                add_item($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 1023),
                         $urandom_range(0, 15), $urandom_range(0, 4095));
            end else begin
                case ($urandom_range(0, 2))
                    0:       y = $urandom_range(0, 4095);
                    1:       y = $urandom_range(0, 40) * 100 + $urandom_range(0, 3);
                    default: y = $urandom_range(4088, 4095);
                endcase
                add_item($urandom_range(0, 400) - 150, $urandom_range(0, 400) - 150,
                         $urandom_range(0, 200) - 60, $urandom_range(0, 70),
                         $urandom_range(1, 12), y);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || push)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        // Give a late spurious result time to appear.
        repeat (150) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS calendar_datetime_normalizer");
        else
            $display("FAIL calendar_datetime_normalizer");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #10_000_000;
        $display("FAIL calendar_datetime_normalizer");
        $finish;
    end

endmodule

[calendar_datetime_normalizer.f]
rtl/cdn_pkg.sv
rtl/cdn_front.sv
rtl/cdn_queue.sv
rtl/cdn_back.sv
rtl/calendar_datetime_normalizer.sv
rtl/cdn_checker.sv
test/tb.sv
